// ===== sv/cnps_pkg.sv =====
// ----------------------------------------------------------------------------
// cnps_pkg
// Types, constants and helper functions for the nearest palette slot block.
// ----------------------------------------------------------------------------
package cnps_pkg;

   localparam int RGB_W        = 24;
   localparam int CHAN_W       = 8;
   localparam int SLOT_W       = 3;
   localparam int PALETTE_SIZE = 8;
   localparam int CSR_INDEX_W  = 4;
   localparam int SQ_W         = 2 * CHAN_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int HASH_WORD_W  = 32;

   localparam logic [HASH_WORD_W-1:0] HASH_MULT = 32'd2654435761;

   // One cache word: valid flag, cached slot and the color it answers for.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [RGB_W-1:0]  color;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Squared distance of one 8-bit channel.
   function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   // Unweighted squared RGB distance between two packed colors.
   function automatic logic [DIST_W-1:0] rgb_dist(input logic [RGB_W-1:0] a,
                                                  input logic [RGB_W-1:0] b);
      logic [DIST_W-1:0] s;
      s = DIST_W'(chan_sq(a[23:16], b[23:16])) +
          DIST_W'(chan_sq(a[15:8], b[15:8])) +
          DIST_W'(chan_sq(a[7:0], b[7:0]));
      return s;
   endfunction

endpackage

// ===== sv/cached_nearest_palette_slot.sv =====
// ----------------------------------------------------------------------------
// cached_nearest_palette_slot
// Maps a 24-bit RGB color to the nearest of eight palette slots, with a
// direct-mapped answer cache in front of the search.
// ----------------------------------------------------------------------------
// One color is in flight at a time and req_tready is low until its answer
// sits in the output register. A cache hit steps from the input transfer
// through hash, cache read, tag check and result load; a miss adds a search,
// because one shared distance unit scores the eight palette slots one per
// cycle. Right after reset, and after any palette register write that
// changes its value, the block sweeps the cache and clears every entry
// (2**CACHE_INDEX_BITS, 64 by default), one per cycle; no color is taken
// during the sweep, but register writes are. Nearness is plain squared RGB
// distance and the lowest slot wins a tie. The cache bucket is the top
// CACHE_INDEX_BITS bits of the low 32 bits of color * 2654435761.
// ----------------------------------------------------------------------------
module cached_nearest_palette_slot #(
   parameter int CACHE_INDEX_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write port
   input  logic                              csr_wr_en,
   input  logic [cnps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cnps_pkg::RGB_W-1:0]        csr_wdata,
   // Color input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // [23:0] color_rgb
   // Slot output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [2:0] slot_index
   output logic                              rsp_tuser    // [0] cache_hit
);

   localparam int CACHE_DEPTH = 2 ** CACHE_INDEX_BITS;
   localparam int SLOT_W      = cnps_pkg::SLOT_W;
   localparam int RGB_W       = cnps_pkg::RGB_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_SEARCH,
      ST_OUT
   } state_type;

   state_type                        state_ff;
   logic [CACHE_INDEX_BITS-1:0]      clear_cnt_ff;
   logic [RGB_W-1:0]                 palette_ff [cnps_pkg::PALETTE_SIZE];
   logic [RGB_W-1:0]                 color_ff;
   logic [CACHE_INDEX_BITS-1:0]      bucket_ff;
   logic [SLOT_W-1:0]                search_cnt_ff;
   logic [SLOT_W-1:0]                best_slot_ff;
   logic [cnps_pkg::DIST_W-1:0]      best_dist_ff;
   logic [SLOT_W-1:0]                result_slot_ff;
   logic                             result_hit_ff;
   logic                             rsp_tvalid_ff;
   logic [SLOT_W-1:0]                rsp_slot_ff;
   logic                             rsp_hit_ff;

   logic                             cfg_change;
   logic [cnps_pkg::HASH_WORD_W-1:0] hash_prod;
   logic [cnps_pkg::DIST_W-1:0]      cur_dist;
   logic                             take_cur;
   logic [SLOT_W-1:0]                final_slot;
   logic                             out_free;

   logic                             ram_wr_en;
   logic [CACHE_INDEX_BITS-1:0]      ram_wr_addr;
   cnps_pkg::entry_type              ram_wr_data;
   cnps_pkg::entry_type              ram_rd_data;

   // A write beyond the last palette register is dropped; rewriting the same
   // value leaves the cache alone.
   assign cfg_change = csr_wr_en &&
                       (csr_index < cnps_pkg::CSR_INDEX_W'(cnps_pkg::PALETTE_SIZE)) &&
                       (palette_ff[csr_index[SLOT_W-1:0]] != csr_wdata);

   assign hash_prod = {{(cnps_pkg::HASH_WORD_W - RGB_W){1'b0}}, color_ff} *
                      cnps_pkg::HASH_MULT;

   // Shared distance unit, stepped over the palette by search_cnt_ff.
   assign cur_dist   = cnps_pkg::rgb_dist(color_ff, palette_ff[search_cnt_ff]);
   assign take_cur   = (search_cnt_ff == '0) || (cur_dist < best_dist_ff);
   assign final_slot = take_cur ? search_cnt_ff : best_slot_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = bucket_ff;
      ram_wr_data = '{valid: 1'b1, slot: final_slot, color: color_ff};
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_SEARCH &&
                   search_cnt_ff == SLOT_W'(cnps_pkg::PALETTE_SIZE - 1)) begin
         ram_wr_en = 1'b1;
      end
   end

   cnps_ram #(
      .WIDTH (cnps_pkg::ENTRY_W),
      .DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (bucket_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_cnt_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < cnps_pkg::PALETTE_SIZE; i++) begin
            palette_ff[i] <= '0;
         end
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + 1'b1;
               if (clear_cnt_ff == CACHE_INDEX_BITS'(CACHE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  color_ff <= req_tdata;
                  state_ff <= ST_HASH;
               end
            end
            ST_HASH: begin
               bucket_ff <= hash_prod[cnps_pkg::HASH_WORD_W-1 -: CACHE_INDEX_BITS];
               state_ff  <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               search_cnt_ff <= '0;
               if (ram_rd_data.valid && ram_rd_data.color == color_ff) begin
                  result_slot_ff <= ram_rd_data.slot;
                  result_hit_ff  <= 1'b1;
                  state_ff       <= ST_OUT;
               end else begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (take_cur) begin
                  best_slot_ff <= search_cnt_ff;
                  best_dist_ff <= cur_dist;
               end
               search_cnt_ff <= search_cnt_ff + 1'b1;
               if (search_cnt_ff == SLOT_W'(cnps_pkg::PALETTE_SIZE - 1)) begin
                  result_slot_ff <= final_slot;
                  result_hit_ff  <= 1'b0;
                  state_ff       <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_slot_ff   <= result_slot_ff;
                  rsp_hit_ff    <= result_hit_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase

         // A changed palette invalidates every cached answer. Writes must only
         // come with no color in flight; the block itself does not enforce it.
         if (cfg_change) begin
            palette_ff[csr_index[SLOT_W-1:0]] <= csr_wdata;
            state_ff                          <= ST_CLEAR;
            clear_cnt_ff                      <= '0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(8 - SLOT_W){1'b0}}, rsp_slot_ff};
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// ===== sv/cnps_ram.sv =====
// ----------------------------------------------------------------------------
// cnps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
